>>> hw/rtl/eagle3x_pkg.sv
// Package with sizes, register indexes and the color match function of the Eagle 3x upscaler.
package eagle3x_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int X_W        = $clog2(MAX_WIDTH);
   localparam int Y_W        = $clog2(MAX_HEIGHT);
   localparam int SIZE_W     = 11;
   localparam int PIX_W      = 32;
   localparam int ADDR_W     = 3;

   localparam logic [SIZE_W-1:0] WIDTH_MAX_C  = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] HEIGHT_MAX_C = SIZE_W'(MAX_HEIGHT);

   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      BLK_UP_LEFT = 2'd0,
      BLK_UP      = 2'd1,
      BLK_LEFT    = 2'd2,
      BLK_HERE    = 2'd3
   } block_type;

   function automatic logic same_rgb(input logic [PIX_W-1:0] p, input logic [PIX_W-1:0] q);
      return p[23:0] == q[23:0];
   endfunction

endpackage

>>> hw/rtl/eagle_3x_pixel_upscaler.sv
// Top level of the Eagle 3x pixel-art upscaler with its line memory and block emitter.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_pixel_rgba
//  rsp     | out       | rsp_valid/rsp_stall | center_x, center_y, sub_row, sub_col, out_rgba, run_last
//  csr     | in/out    | APB psel/penable    | image_width, image_height
//
// A pixel reads the line memory at its accept edge, waits in the window stage and updates
// the window once the emitter is free.
// Each emitted block has nine cells, sent on rsp one cell per cycle while rsp is not stalled;
// a pixel emits one block in the steady state and two or four at line and frame ends.
// Reset is synchronous and needs no clearing pass; the line memory is never read unwritten
// where it matters. A stall on rsp holds the emitter and, once the next pixel waits, req.
module eagle_3x_pixel_upscaler
   import eagle3x_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [PIX_W-1:0]  req_pixel_rgba,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [X_W-1:0]    rsp_center_x,
   output logic [Y_W-1:0]    rsp_center_y,
   output logic [1:0]        rsp_sub_row,
   output logic [1:0]        rsp_sub_col,
   output logic [PIX_W-1:0]  rsp_out_rgba,
   output logic              rsp_run_last,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [SIZE_W-1:0] width_ff, height_ff;
   logic [SIZE_W-1:0] wdt, hgt;
   logic              csr_wr;

   logic [X_W-1:0]    col_ff, col_in;
   logic [Y_W-1:0]    line_ff, line_in;
   logic              req_acc, end_line, end_frame;

   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_ff, fwd_data_ff, line_rd, wr_data;
   logic               fwd_ff;

   logic              b_ff;
   logic [X_W-1:0]    b_x_ff;
   logic [Y_W-1:0]    b_y_ff;
   logic [PIX_W-1:0]  b_pix_ff;
   logic              b_end_line_ff, b_end_frame_ff;
   logic              b_adv;

   logic [PIX_W-1:0]  win_ff [9];
   logic [PIX_W-1:0]  win_in [9];
   logic [3:0]        mask_new;
   logic              eagle_new;

   logic              job_ff;
   logic [PIX_W-1:0]  job_win_ff [9];
   logic [X_W-1:0]    job_x_ff;
   logic [Y_W-1:0]    job_y_ff;
   logic              job_eagle_ff;
   logic [3:0]        job_mask_ff;
   logic [1:0]        job_row_ff, job_col_ff;
   block_type         cur;
   logic              last_blk, cell_last, step, job_done;

   logic c0, c1, c2, c3, c5, c6, c7, c8;
   logic [PIX_W-1:0] wa, wb, wc, wd, we, wf, wg, wh, wj, eagle_cell, copy_cell;

   // Configuration port.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_MAX_C;
         height_ff <= HEIGHT_MAX_C;
      end else if (csr_wr) begin
         unique case (reg_index_type'(paddr[2]))
            REG_IMAGE_WIDTH:  width_ff  <= pwdata[SIZE_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(paddr[2]))
         REG_IMAGE_WIDTH:  prdata = {{(32-SIZE_W){1'b0}}, width_ff};
         REG_IMAGE_HEIGHT: prdata = {{(32-SIZE_W){1'b0}}, height_ff};
         default:          prdata = '0;
      endcase
   end

   assign wdt = (width_ff == '0) ? SIZE_W'(1) : (width_ff > WIDTH_MAX_C) ? WIDTH_MAX_C : width_ff;
   assign hgt = (height_ff == '0) ? SIZE_W'(1) :
                (height_ff > HEIGHT_MAX_C) ? HEIGHT_MAX_C : height_ff;

   // Position counters advance at the accept edge.
   assign req_stall = b_ff && !b_adv;
   assign req_acc   = req_valid && !req_stall;
   assign end_line  = (SIZE_W'(col_ff) + SIZE_W'(1)) >= wdt;
   assign end_frame = (SIZE_W'(line_ff) + SIZE_W'(1)) >= hgt;

   always_comb begin
      col_in  = col_ff;
      line_in = line_ff;
      if (req_acc) begin
         if (end_line) begin
            col_in  = '0;
            line_in = end_frame ? '0 : line_ff + Y_W'(1);
         end else begin
            col_in = col_ff + X_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         line_ff <= '0;
      end else begin
         col_ff  <= col_in;
         line_ff <= line_in;
      end
   end

   // Line memory: older line in the upper half, newer line in the lower half.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         rd_ff <= line_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         line_mem[b_x_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         fwd_ff      <= b_adv && (b_x_ff == col_ff);
         fwd_data_ff <= wr_data;
      end
   end

   assign line_rd = fwd_ff ? fwd_data_ff : rd_ff;
   assign wr_data = {line_rd[PIX_W-1:0], b_pix_ff};

   // Window stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff <= 1'b0;
      end else if (req_acc) begin
         b_ff <= 1'b1;
      end else if (b_adv) begin
         b_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         b_x_ff         <= col_ff;
         b_y_ff         <= line_ff;
         b_pix_ff       <= req_pixel_rgba;
         b_end_line_ff  <= end_line;
         b_end_frame_ff <= end_frame;
      end
   end

   assign b_adv = b_ff && (!job_ff || job_done);

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r*3]   = win_ff[r*3+1];
         win_in[r*3+1] = win_ff[r*3+2];
      end
      win_in[2] = line_rd[2*PIX_W-1:PIX_W];
      win_in[5] = line_rd[PIX_W-1:0];
      win_in[8] = b_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else if (b_adv) begin
         for (int i = 0; i < 9; i++) win_ff[i] <= win_in[i];
      end
   end

   assign mask_new[0] = (b_x_ff != '0) && (b_y_ff != '0);
   assign mask_new[1] = b_end_line_ff && (b_y_ff != '0);
   assign mask_new[2] = b_end_frame_ff && (b_x_ff != '0);
   assign mask_new[3] = b_end_line_ff && b_end_frame_ff;
   assign eagle_new   = (b_x_ff >= X_W'(2)) && (SIZE_W'(b_x_ff) < wdt) &&
                        (b_y_ff >= Y_W'(2)) && (SIZE_W'(b_y_ff) < hgt);

   // Block emitter.
   always_comb begin
      priority if (job_mask_ff[0]) cur = BLK_UP_LEFT;
      else if (job_mask_ff[1])     cur = BLK_UP;
      else if (job_mask_ff[2])     cur = BLK_LEFT;
      else                         cur = BLK_HERE;
   end

   assign last_blk  = $countones(job_mask_ff) == 1;
   assign cell_last = (job_row_ff == 2'd2) && (job_col_ff == 2'd2);
   assign step      = job_ff && !rsp_stall;
   assign job_done  = step && cell_last && last_blk;

   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff      <= 1'b0;
         job_mask_ff <= '0;
         job_row_ff  <= '0;
         job_col_ff  <= '0;
      end else if (b_adv && (mask_new != '0)) begin
         job_ff      <= 1'b1;
         job_mask_ff <= mask_new;
         job_row_ff  <= '0;
         job_col_ff  <= '0;
      end else if (job_done) begin
         job_ff      <= 1'b0;
         job_mask_ff <= '0;
         job_row_ff  <= '0;
         job_col_ff  <= '0;
      end else if (step) begin
         if (job_col_ff == 2'd2) begin
            job_col_ff <= '0;
            if (job_row_ff == 2'd2) begin
               job_row_ff       <= '0;
               job_mask_ff[cur] <= 1'b0;
            end else begin
               job_row_ff <= job_row_ff + 2'd1;
            end
         end else begin
            job_col_ff <= job_col_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv && (mask_new != '0)) begin
         for (int i = 0; i < 9; i++) job_win_ff[i] <= win_in[i];
         job_x_ff     <= b_x_ff;
         job_y_ff     <= b_y_ff;
         job_eagle_ff <= eagle_new;
      end
   end

   assign wa = job_win_ff[0];
   assign wb = job_win_ff[1];
   assign wc = job_win_ff[2];
   assign wd = job_win_ff[3];
   assign we = job_win_ff[4];
   assign wf = job_win_ff[5];
   assign wg = job_win_ff[6];
   assign wh = job_win_ff[7];
   assign wj = job_win_ff[8];

   assign c0 = same_rgb(wa, wb) && same_rgb(wb, wd);
   assign c1 = c0 && same_rgb(wb, wc) && same_rgb(wc, wf);
   assign c2 = same_rgb(wb, wc) && same_rgb(wc, wf);
   assign c3 = c0 && same_rgb(wd, wg) && same_rgb(wg, wh);
   assign c5 = c2 && same_rgb(wf, wj) && same_rgb(wj, wh);
   assign c6 = same_rgb(wd, wg) && same_rgb(wg, wh);
   assign c7 = c6 && same_rgb(wh, wj) && same_rgb(wj, wf);
   assign c8 = same_rgb(wf, wj) && same_rgb(wj, wh);

   always_comb begin
      eagle_cell = we;
      unique case (job_row_ff)
         2'd0: begin
            unique case (job_col_ff)
               2'd0:    eagle_cell = c0 ? wd : we;
               2'd1:    eagle_cell = c1 ? wd : we;
               default: eagle_cell = c2 ? wf : we;
            endcase
         end
         2'd1: begin
            unique case (job_col_ff)
               2'd0:    eagle_cell = c3 ? wd : we;
               2'd1:    eagle_cell = we;
               default: eagle_cell = c5 ? wf : we;
            endcase
         end
         default: begin
            unique case (job_col_ff)
               2'd0:    eagle_cell = c6 ? wd : we;
               2'd1:    eagle_cell = c7 ? wd : we;
               default: eagle_cell = c8 ? wf : we;
            endcase
         end
      endcase
   end

   always_comb begin
      unique case (cur)
         BLK_UP_LEFT: copy_cell = we;
         BLK_UP:      copy_cell = wf;
         BLK_LEFT:    copy_cell = wh;
         BLK_HERE:    copy_cell = wj;
         default:     copy_cell = we;
      endcase
   end

   assign rsp_valid    = job_ff;
   assign rsp_center_x = ((cur == BLK_UP_LEFT) || (cur == BLK_LEFT)) ? job_x_ff - X_W'(1)
                                                                     : job_x_ff;
   assign rsp_center_y = ((cur == BLK_UP_LEFT) || (cur == BLK_UP)) ? job_y_ff - Y_W'(1)
                                                                   : job_y_ff;
   assign rsp_sub_row  = job_row_ff;
   assign rsp_sub_col  = job_col_ff;
   assign rsp_out_rgba = ((cur == BLK_UP_LEFT) && job_eagle_ff) ? eagle_cell : copy_cell;
   assign rsp_run_last = cell_last && last_blk;

`ifndef SYNTHESIS
   a_job_has_block: assert property (@(posedge clock) disable iff (reset)
      job_ff |-> (job_mask_ff != '0))
      else $error("Emitter is busy without a pending block.");

   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !b_ff |-> !req_stall)
      else $error("Input stalled while the window stage is empty.");

   a_last_ends_block: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_run_last) |-> (rsp_sub_row == 2'd2 && rsp_sub_col == 2'd2))
      else $error("Last result of a transaction is not the final cell of a block.");

   a_job_ends_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_run_last && !rsp_stall && !b_adv) |=> !rsp_valid)
      else $error("Results continue after the last one of a transaction.");
`endif

endmodule
